>>> rtl/core/rbse_pkg.sv
// Shared types and constants for the range bitmap set engine.
`timescale 1ns / 1ps

package rbse_pkg;

  // Fixed field widths of the stream words
  localparam int unsigned VAL_W     = 10;
  localparam int unsigned WIDX_W    = 4;
  localparam int unsigned OPND_W    = 64;
  localparam int unsigned FOUND_W   = 11;
  localparam int unsigned KIND_W    = 3;

  // Default geometry of the bitmap
  localparam int unsigned DEF_NUM_WORDS = 16;
  localparam int unsigned DEF_WORD_BITS = 64;

  // Request kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_ADD        = 3'd0,
    KIND_REMOVE     = 3'd1,
    KIND_FIND_FIRST = 3'd2,
    KIND_FIND_NEXT  = 3'd3,
    KIND_OR         = 3'd4,
    KIND_AND        = 3'd5,
    KIND_XOR        = 3'd6,
    KIND_ANDNOT     = 3'd7
  } kind_e;

  // Request control held for the length of one walk
  typedef struct packed {
    kind_e            kind;
    logic [VAL_W-1:0] lo;
    logic [VAL_W-1:0] hi;
    logic [VAL_W:0]   start;
  } word_ctl_t;

endpackage

>>> rtl/core/rbse_word_unit.sv
// Per-word unit: range mask, masked search and word update for one bitmap word.
`timescale 1ns / 1ps

module rbse_word_unit #(
  parameter int unsigned WORD_BITS = rbse_pkg::DEF_WORD_BITS,
  parameter int unsigned CMP_W     = 17
) (
  input  rbse_pkg::word_ctl_t   ctl_i,
  input  logic [CMP_W-1:0]      base_i,
  input  logic [WORD_BITS-1:0]  rdata_i,
  input  logic [WORD_BITS-1:0]  operand_i,
  output logic [WORD_BITS-1:0]  wdata_o,
  output logic                  hit_o,
  output logic [CMP_W-1:0]      hit_pos_o
);

  localparam int unsigned OFF_W = $clog2(WORD_BITS);
  localparam logic [WORD_BITS-1:0] ONES  = {WORD_BITS{1'b1}};
  localparam logic [OFF_W-1:0]     WB_M1 = OFF_W'(WORD_BITS - 1);

  logic [CMP_W-1:0]     lo_x, hi_x, st_x, top;
  logic [CMP_W-1:0]     lo_off, hi_off, st_off;
  logic [OFF_W-1:0]     a_off, b_off, bit_idx;
  logic [WORD_BITS-1:0] rng_mask, fnd_mask, cand;

  // Range mask: bits of this word that lie inside lo..hi
  always_comb begin
    lo_x   = CMP_W'(ctl_i.lo);
    hi_x   = CMP_W'(ctl_i.hi);
    top    = base_i + CMP_W'(WORD_BITS - 1);
    lo_off = lo_x - base_i;
    hi_off = hi_x - base_i;
    a_off  = (lo_x > base_i) ? lo_off[OFF_W-1:0] : '0;
    b_off  = (hi_x < top) ? hi_off[OFF_W-1:0] : WB_M1;
    if (hi_x < base_i || lo_x > top) begin
      rng_mask = '0;
    end else begin
      rng_mask = (ONES >> (WB_M1 - b_off)) & (ONES << a_off);
    end
  end

  // Search mask: bits at or above the start value
  always_comb begin
    st_x   = CMP_W'(ctl_i.start);
    st_off = st_x - base_i;
    if (st_x <= base_i) begin
      fnd_mask = ONES;
    end else if (st_off >= CMP_W'(WORD_BITS)) begin
      fnd_mask = '0;
    end else begin
      fnd_mask = ONES << st_off[OFF_W-1:0];
    end
  end

  // Lowest candidate bit
  always_comb begin
    cand    = rdata_i & fnd_mask;
    bit_idx = '0;
    for (int k = WORD_BITS - 1; k >= 0; k--) begin
      if (cand[k]) bit_idx = OFF_W'(k);
    end
    hit_o     = |cand;
    hit_pos_o = base_i + CMP_W'(bit_idx);
  end

  // Updated word
  always_comb begin
    unique case (ctl_i.kind)
      rbse_pkg::KIND_ADD:    wdata_o = rdata_i | rng_mask;
      rbse_pkg::KIND_REMOVE: wdata_o = rdata_i & ~rng_mask;
      rbse_pkg::KIND_OR:     wdata_o = rdata_i | operand_i;
      rbse_pkg::KIND_AND:    wdata_o = rdata_i & operand_i;
      rbse_pkg::KIND_XOR:    wdata_o = rdata_i ^ operand_i;
      rbse_pkg::KIND_ANDNOT: wdata_o = rdata_i & ~operand_i;
      default:               wdata_o = rdata_i;
    endcase
  end

endmodule

>>> rtl/core/range_bitmap_set_engine_top.sv
// Top level of the range bitmap set engine: sequencer, bitmap memory and output register.
`timescale 1ns / 1ps

// The engine holds a set of values 0..NUM_WORDS*WORD_BITS-1 as NUM_WORDS bitmap words in a
// single-port-read memory, and answers every request word with exactly one result word.
// After reset a clearing pass writes zero to every word, one per cycle, and the input is not
// ready until it is done. Requests are handled one at a time by a walk over the memory that
// reads one word per cycle through the read port; add, remove and word combines write it
// back through the per-word unit. Add and remove walk from word 0 up to the word that holds
// high_value. Find first and find next walk from word 0 until a member turns up, or over every
// word when there is none. Word combines read and write back only the word at word_index; a
// bad range or a word index beyond the bitmap ends the request without a walk.
// set_empty comes from a count of non-zero words kept beside the memory.

module range_bitmap_set_engine_top #(
  parameter int unsigned NUM_WORDS = rbse_pkg::DEF_NUM_WORDS,
  parameter int unsigned WORD_BITS = rbse_pkg::DEF_WORD_BITS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // tdata: low_value[9:0], high_value[19:10], word_index[23:20], operand_word[87:24]
  input  logic [87:0] s_axis_tdata,
  // tuser: kind[2:0]
  input  logic [2:0]  s_axis_tuser,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata: found_value[10:0], set_empty[11], bad_range[12], zero[15:13]
  output logic [15:0] m_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready
);

  localparam int unsigned VAL_W      = rbse_pkg::VAL_W;
  localparam int unsigned FOUND_W    = rbse_pkg::FOUND_W;
  localparam int unsigned TOTAL_BITS = NUM_WORDS * WORD_BITS;
  localparam int unsigned BASE_W0    = $clog2(TOTAL_BITS + WORD_BITS + 1);
  localparam int unsigned CMP_W      = (BASE_W0 > FOUND_W) ? BASE_W0 : FOUND_W;
  localparam int unsigned IDX_W      = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int unsigned CNT_W      = $clog2(NUM_WORDS + 1);
  localparam logic [IDX_W-1:0]   LAST_IDX   = IDX_W'(NUM_WORDS - 1);
  localparam logic [FOUND_W-1:0] FOUND_NONE = FOUND_W'(TOTAL_BITS);

  // Input word layout
  localparam int unsigned LO_POS   = 0;
  localparam int unsigned HI_POS   = LO_POS + VAL_W;
  localparam int unsigned WIDX_POS = HI_POS + VAL_W;
  localparam int unsigned OPND_POS = WIDX_POS + rbse_pkg::WIDX_W;

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_WALK  = 4'b0100,
    ST_DONE  = 4'b1000
  } state_e;

  state_e                  state_q, state_d;
  logic [IDX_W-1:0]        clr_idx_q, clr_idx_d;
  rbse_pkg::word_ctl_t     ctl_q, ctl_d;
  logic [WORD_BITS-1:0]    opnd_q, opnd_d;
  logic                    iss_act_q, iss_act_d;
  logic [IDX_W-1:0]        iss_idx_q, iss_idx_d;
  logic [CMP_W-1:0]        iss_base_q, iss_base_d;
  logic                    p_vld_q, p_vld_d;
  logic                    p_last_q, p_last_d;
  logic [IDX_W-1:0]        p_idx_q, p_idx_d;
  logic [CMP_W-1:0]        p_base_q, p_base_d;
  logic [FOUND_W-1:0]      found_q, found_d;
  logic                    bad_q, bad_d;
  logic [CNT_W-1:0]        cnt_q, cnt_d;
  logic                    out_vld_q, out_vld_d;
  logic [FOUND_W-1:0]      out_found_q, out_found_d;
  logic                    out_empty_q, out_empty_d;
  logic                    out_bad_q, out_bad_d;

  logic [WORD_BITS-1:0]    bitmap_q [NUM_WORDS];
  logic [WORD_BITS-1:0]    rdata_q;
  logic                    mem_we;
  logic [IDX_W-1:0]        mem_waddr;
  logic [WORD_BITS-1:0]    mem_wdata;
  logic [IDX_W-1:0]        mem_raddr;

  logic                    is_find, is_range, is_comb;
  logic [CMP_W-1:0]        next_base;
  logic                    iss_last;
  logic                    walk_done;
  logic [WORD_BITS-1:0]    unit_wdata;
  logic                    unit_hit;
  logic [CMP_W-1:0]        unit_pos;
  rbse_pkg::kind_e         in_kind;
  logic [VAL_W-1:0]        in_lo, in_hi;
  logic [rbse_pkg::WIDX_W-1:0] in_widx;

  assign in_kind = rbse_pkg::kind_e'(s_axis_tuser);
  assign in_lo   = s_axis_tdata[LO_POS +: VAL_W];
  assign in_hi   = s_axis_tdata[HI_POS +: VAL_W];
  assign in_widx = s_axis_tdata[WIDX_POS +: rbse_pkg::WIDX_W];

  assign is_find  = (ctl_q.kind == rbse_pkg::KIND_FIND_FIRST) ||
                    (ctl_q.kind == rbse_pkg::KIND_FIND_NEXT);
  assign is_range = (ctl_q.kind == rbse_pkg::KIND_ADD) ||
                    (ctl_q.kind == rbse_pkg::KIND_REMOVE);
  assign is_comb  = !is_find && !is_range;

  // Issue side: last word to read for this request
  assign next_base = iss_base_q + CMP_W'(WORD_BITS);
  assign iss_last  = is_comb || (iss_idx_q == LAST_IDX) ||
                     (is_range && (next_base > CMP_W'(ctl_q.hi)));

  rbse_word_unit #(
    .WORD_BITS (WORD_BITS),
    .CMP_W     (CMP_W)
  ) u_word (
    .ctl_i     (ctl_q),
    .base_i    (p_base_q),
    .rdata_i   (rdata_q),
    .operand_i (opnd_q),
    .wdata_o   (unit_wdata),
    .hit_o     (unit_hit),
    .hit_pos_o (unit_pos)
  );

  // Sequencer
  always_comb begin
    state_d     = state_q;
    clr_idx_d   = clr_idx_q;
    ctl_d       = ctl_q;
    opnd_d      = opnd_q;
    iss_act_d   = iss_act_q;
    iss_idx_d   = iss_idx_q;
    iss_base_d  = iss_base_q;
    p_vld_d     = 1'b0;
    p_last_d    = p_last_q;
    p_idx_d     = p_idx_q;
    p_base_d    = p_base_q;
    found_d     = found_q;
    bad_d       = bad_q;
    cnt_d       = cnt_q;
    out_vld_d   = out_vld_q && !m_axis_tready;
    out_found_d = out_found_q;
    out_empty_d = out_empty_q;
    out_bad_d   = out_bad_q;
    mem_we      = 1'b0;
    mem_waddr   = p_idx_q;
    mem_wdata   = unit_wdata;
    mem_raddr   = iss_idx_q;
    walk_done   = 1'b0;

    unique case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_idx_q;
        mem_wdata = '0;
        if (clr_idx_q == LAST_IDX) begin
          state_d = ST_IDLE;
        end else begin
          clr_idx_d = clr_idx_q + 1'b1;
        end
      end

      ST_IDLE: begin
        if (s_axis_tvalid) begin
          ctl_d.kind  = in_kind;
          ctl_d.lo    = in_lo;
          ctl_d.hi    = in_hi;
          ctl_d.start = '0;
          opnd_d      = s_axis_tdata[OPND_POS +: WORD_BITS];
          found_d     = '0;
          bad_d       = 1'b0;
          iss_act_d   = 1'b1;
          iss_idx_d   = '0;
          iss_base_d  = '0;
          state_d     = ST_WALK;
          case (in_kind) inside
            rbse_pkg::KIND_ADD, rbse_pkg::KIND_REMOVE: begin
              if (in_lo > in_hi) begin
                bad_d   = 1'b1;
                state_d = ST_DONE;
              end
            end
            rbse_pkg::KIND_FIND_FIRST: ctl_d.start = '0;
            rbse_pkg::KIND_FIND_NEXT:  ctl_d.start = {1'b0, in_lo} + 1'b1;
            default: begin
              if (32'(in_widx) < NUM_WORDS) begin
                iss_idx_d = IDX_W'(in_widx);
              end else begin
                state_d = ST_DONE;
              end
            end
          endcase
        end
      end

      ST_WALK: begin
        // read one word per cycle
        if (iss_act_q) begin
          p_vld_d  = 1'b1;
          p_idx_d  = iss_idx_q;
          p_base_d = iss_base_q;
          p_last_d = iss_last;
          if (iss_last) begin
            iss_act_d = 1'b0;
          end else begin
            iss_idx_d  = iss_idx_q + 1'b1;
            iss_base_d = next_base;
          end
        end
        // handle the word read last cycle
        if (p_vld_q) begin
          if (is_find) begin
            if (unit_hit) begin
              found_d   = unit_pos[FOUND_W-1:0];
              walk_done = 1'b1;
            end else if (p_last_q) begin
              found_d   = FOUND_NONE;
              walk_done = 1'b1;
            end
          end else begin
            mem_we = 1'b1;
            if ((|unit_wdata) && !(|rdata_q)) begin
              cnt_d = cnt_q + 1'b1;
            end else if (!(|unit_wdata) && (|rdata_q)) begin
              cnt_d = cnt_q - 1'b1;
            end
            walk_done = p_last_q;
          end
          if (walk_done) begin
            state_d   = ST_DONE;
            iss_act_d = 1'b0;
            p_vld_d   = 1'b0;
          end
        end
      end

      ST_DONE: begin
        if (!out_vld_q || m_axis_tready) begin
          out_vld_d   = 1'b1;
          out_found_d = found_q;
          out_empty_d = (cnt_q == '0);
          out_bad_d   = bad_q;
          state_d     = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_idx_q <= '0;
      iss_act_q <= 1'b0;
      p_vld_q   <= 1'b0;
      cnt_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_idx_q <= clr_idx_d;
      iss_act_q <= iss_act_d;
      p_vld_q   <= p_vld_d;
      cnt_q     <= cnt_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    ctl_q       <= ctl_d;
    opnd_q      <= opnd_d;
    iss_idx_q   <= iss_idx_d;
    iss_base_q  <= iss_base_d;
    p_last_q    <= p_last_d;
    p_idx_q     <= p_idx_d;
    p_base_q    <= p_base_d;
    found_q     <= found_d;
    bad_q       <= bad_d;
    out_found_q <= out_found_d;
    out_empty_q <= out_empty_d;
    out_bad_q   <= out_bad_d;
  end

  // Bitmap memory: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      bitmap_q[mem_waddr] <= mem_wdata;
    end
    rdata_q <= bitmap_q[mem_raddr];
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {3'b000, out_bad_q, out_empty_q, out_found_q};

  // Checks
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(NUM_WORDS))
    else $error("non-zero word count beyond bitmap size");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input ready again straight after accepting a word");

  a_pipe_in_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    p_vld_q |-> (state_q == ST_WALK))
    else $error("word in flight outside a walk");

  a_bad_no_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_bad_q) |-> (out_found_q == '0))
    else $error("bad range result carries a found value");

endmodule

>>> bench/range_bitmap_set_engine_top_tb.sv
// Self-checking bench for the range bitmap set engine: stream driver, monitor and predictor.
`timescale 1ns / 1ps

module range_bitmap_set_engine_top_tb;

  localparam int unsigned NUM_WORDS      = rbse_pkg::DEF_NUM_WORDS;
  localparam int unsigned WORD_BITS      = rbse_pkg::DEF_WORD_BITS;
  localparam int unsigned VAL_W          = rbse_pkg::VAL_W;
  localparam int unsigned WIDX_W         = rbse_pkg::WIDX_W;
  localparam int unsigned OPND_W         = rbse_pkg::OPND_W;
  localparam int unsigned FOUND_W        = rbse_pkg::FOUND_W;
  localparam int unsigned TOTAL_BITS     = NUM_WORDS * WORD_BITS;
  localparam int unsigned RANDOM_PER_PHASE = 225;
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned DRAIN_CYCLES   = 40;
  localparam int unsigned CYCLE_LIMIT    = 500000;

  // One request word as the block sees it
  typedef struct packed {
    rbse_pkg::kind_e    kind;
    logic [VAL_W-1:0]   low;
    logic [VAL_W-1:0]   high;
    logic [WIDX_W-1:0]  widx;
    logic [OPND_W-1:0]  operand;
  } set_request_t;

  // One answer word
  typedef struct packed {
    logic [FOUND_W-1:0] found;
    logic               empty;
    logic               bad;
  } set_answer_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic [87:0] s_axis_tdata = '0;
  logic [2:0]  s_axis_tuser = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] m_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;

  range_bitmap_set_engine_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready)
  );

  // Predicted membership, one bit per value
  logic [WORD_BITS-1:0] member_words [NUM_WORDS];

  set_request_t pending_requests[$];
  set_answer_t  expected_answers[$];
  set_request_t offered;
  set_answer_t  want, got;

  int unsigned sender_idle_pct = 0;
  int unsigned recv_stall_pct  = 0;
  logic        hold_armed = 1'b0;
  logic        hold_done  = 1'b0;
  int unsigned hold_count = 0;
  int unsigned cycle_count = 0;
  int unsigned requests_taken = 0;
  int unsigned answers_seen = 0;
  int unsigned mismatches = 0;
  int unsigned none_found = 0;
  int unsigned bad_ranges = 0;
  int unsigned kind_seen [8];

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Smallest member at or above start, TOTAL_BITS when there is none
  function automatic int unsigned first_member_from(int unsigned start);
    int unsigned b;
    for (b = start; b < TOTAL_BITS; b++) begin
      if (member_words[b / WORD_BITS][b % WORD_BITS]) return b;
    end
    return TOTAL_BITS;
  endfunction

  // Apply one request to the predicted set and work out its answer
  function automatic set_answer_t apply_request(set_request_t rq);
    set_answer_t ans;
    int unsigned v;
    ans = '0;
    case (rq.kind) inside
      rbse_pkg::KIND_ADD, rbse_pkg::KIND_REMOVE: begin
        if (rq.low > rq.high) begin
          ans.bad = 1'b1;
        end else begin
          for (v = rq.low; v <= rq.high; v++)
            member_words[v / WORD_BITS][v % WORD_BITS] = (rq.kind == rbse_pkg::KIND_ADD);
        end
      end
      rbse_pkg::KIND_FIND_FIRST: ans.found = FOUND_W'(first_member_from(0));
      rbse_pkg::KIND_FIND_NEXT:  ans.found = FOUND_W'(first_member_from(int'(rq.low) + 1));
      rbse_pkg::KIND_OR:
        member_words[rq.widx] = member_words[rq.widx] | rq.operand;
      rbse_pkg::KIND_AND:
        member_words[rq.widx] = member_words[rq.widx] & rq.operand;
      rbse_pkg::KIND_XOR:
        member_words[rq.widx] = member_words[rq.widx] ^ rq.operand;
      rbse_pkg::KIND_ANDNOT:
        member_words[rq.widx] = member_words[rq.widx] & ~rq.operand;
      default: ;
    endcase
    ans.empty = 1'b1;
    foreach (member_words[w]) if (member_words[w] != '0) ans.empty = 1'b0;
    return ans;
  endfunction

  function automatic set_request_t req(rbse_pkg::kind_e k, int unsigned lo, int unsigned hi,
                                       int unsigned idx, logic [OPND_W-1:0] op);
    set_request_t rq;
    rq.kind    = k;
    rq.low     = VAL_W'(lo);
    rq.high    = VAL_W'(hi);
    rq.widx    = WIDX_W'(idx);
    rq.operand = op;
    return rq;
  endfunction

  // Mostly sensible ranges and searches, with some reversed ranges and odd operands
  function automatic set_request_t random_request();
    set_request_t rq;
    int unsigned pick;
    int unsigned span;
    rq.low     = VAL_W'($urandom_range(TOTAL_BITS - 1));
    rq.high    = VAL_W'($urandom_range(TOTAL_BITS - 1));
    rq.widx    = WIDX_W'($urandom_range(NUM_WORDS - 1));
    rq.operand = {$urandom, $urandom};
    pick = $urandom_range(99);
    if (pick < 25)      rq.kind = rbse_pkg::KIND_ADD;
    else if (pick < 40) rq.kind = rbse_pkg::KIND_REMOVE;
    else if (pick < 50) rq.kind = rbse_pkg::KIND_FIND_FIRST;
    else if (pick < 70) rq.kind = rbse_pkg::KIND_FIND_NEXT;
    else                rq.kind = rbse_pkg::kind_e'($urandom_range(7, 4));
    pick = $urandom_range(99);
    case (rq.kind) inside
      rbse_pkg::KIND_ADD, rbse_pkg::KIND_REMOVE: begin
        if (pick < 8) begin
          // reversed range
          rq.high = VAL_W'($urandom_range(TOTAL_BITS - 2));
          rq.low  = VAL_W'($urandom_range(TOTAL_BITS - 1, int'(rq.high) + 1));
        end else if (pick < 11) begin
          rq.low  = '0;
          rq.high = '1;
        end else begin
          span = (pick < 70) ? $urandom_range(40) :
                 (pick < 90) ? $urandom_range(200) : $urandom_range(TOTAL_BITS - 1);
          rq.high = (int'(rq.low) + span > TOTAL_BITS - 1) ? '1 : VAL_W'(rq.low + span);
        end
      end
      rbse_pkg::KIND_FIND_NEXT: if (pick < 5) rq.low = '1;
      rbse_pkg::KIND_OR, rbse_pkg::KIND_AND, rbse_pkg::KIND_XOR,
      rbse_pkg::KIND_ANDNOT: begin
        if (pick < 10)      rq.operand = '1;
        else if (pick < 20) rq.operand = '0;
        else if (pick < 35) rq.operand = 64'd1 << $urandom_range(63);
        else if (pick < 50) rq.operand = rq.operand & {$urandom, $urandom} & {$urandom, $urandom};
      end
      default: ;
    endcase
    return rq;
  endfunction

  task automatic wait_drained();
    while (pending_requests.size() != 0 || s_axis_tvalid || expected_answers.size() != 0)
      @(negedge clk_i);
  endtask

  // Driver: predicts each accepted word, then offers the next one
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        want = apply_request(offered);
        expected_answers.push_back(want);
        requests_taken++;
        kind_seen[offered.kind]++;
        if (want.bad) bad_ranges++;
        if (want.found == FOUND_W'(TOTAL_BITS)) none_found++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_requests.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          offered = pending_requests.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {offered.operand, offered.widx, offered.high, offered.low};
          s_axis_tuser  <= offered.kind;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, run once
  always @(posedge clk_i) begin
    if (hold_armed && !hold_done) begin
      if (hold_count == HOLD_CYCLES - 1) hold_done <= 1'b1;
      hold_count <= hold_count + 1;
    end
  end

  // Monitor: checks each answer word against the oldest prediction
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        answers_seen++;
        got.found = m_axis_tdata[10:0];
        got.empty = m_axis_tdata[11];
        got.bad   = m_axis_tdata[12];
        if (expected_answers.size() == 0) begin
          mismatches++;
          $display("%0t: answer with nothing expected: found=%0d empty=%0b bad=%0b",
                   $time, got.found, got.empty, got.bad);
        end else begin
          want = expected_answers.pop_front();
          if (got != want) begin
            mismatches++;
            $display("%0t: expected found=%0d empty=%0b bad=%0b,",
                     $time, want.found, want.empty, want.bad,
                     " got found=%0d empty=%0b bad=%0b",
                     got.found, got.empty, got.bad);
          end
        end
      end
      m_axis_tready <= !(hold_armed && !hold_done) && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d answers outstanding",
               $time, cycle_count, expected_answers.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Stimulus: four idling phases, directed words first
  initial begin
    int unsigned sender_pcts [4];
    int unsigned recv_pcts [4];
    sender_pcts = '{0, 58, 0, 29};
    recv_pcts   = '{0, 0, 58, 29};
    foreach (member_words[w]) member_words[w] = '0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    for (int p = 0; p < 4; p++) begin
      @(negedge clk_i);
      sender_idle_pct = sender_pcts[p];
      recv_stall_pct  = recv_pcts[p];
      if (p == 0) begin
        // empty set searches, both ends of the value range, top-of-range find next
        pending_requests.push_back(req(rbse_pkg::KIND_FIND_FIRST, 0, 0, 0, '0));
        pending_requests.push_back(req(rbse_pkg::KIND_FIND_NEXT, 0, 0, 0, '0));
        pending_requests.push_back(req(rbse_pkg::KIND_ADD, 0, 0, 0, '0));
        pending_requests.push_back(req(rbse_pkg::KIND_ADD, 1023, 1023, 0, '0));
        pending_requests.push_back(req(rbse_pkg::KIND_FIND_FIRST, 0, 0, 0, '0));
        pending_requests.push_back(req(rbse_pkg::KIND_FIND_NEXT, 0, 0, 0, '0));
        pending_requests.push_back(req(rbse_pkg::KIND_FIND_NEXT, 1022, 0, 0, '0));
        pending_requests.push_back(req(rbse_pkg::KIND_FIND_NEXT, 1023, 0, 0, '0));
        // reversed ranges leave the set alone
        pending_requests.push_back(req(rbse_pkg::KIND_ADD, 5, 4, 0, '0));
        pending_requests.push_back(req(rbse_pkg::KIND_REMOVE, 1023, 0, 0, '0));
        // whole-range fill and clear, a hole across one word
        pending_requests.push_back(req(rbse_pkg::KIND_ADD, 0, 1023, 0, '0));
        pending_requests.push_back(req(rbse_pkg::KIND_REMOVE, 64, 127, 0, '0));
        pending_requests.push_back(req(rbse_pkg::KIND_FIND_NEXT, 63, 0, 0, '0));
        pending_requests.push_back(req(rbse_pkg::KIND_REMOVE, 0, 1023, 0, '0));
        // word combines on the first and last words
        pending_requests.push_back(req(rbse_pkg::KIND_OR, 0, 0, 0, '1));
        pending_requests.push_back(req(rbse_pkg::KIND_AND, 0, 0, 0, {32{2'b01}}));
        pending_requests.push_back(req(rbse_pkg::KIND_XOR, 0, 0, 15, '1));
        pending_requests.push_back(req(rbse_pkg::KIND_ANDNOT, 0, 0, 0, '1));
        pending_requests.push_back(req(rbse_pkg::KIND_FIND_FIRST, 0, 0, 0, '0));
        pending_requests.push_back(req(rbse_pkg::KIND_ANDNOT, 0, 0, 15, '1));
        // single-value hole in a mid-range run
        pending_requests.push_back(req(rbse_pkg::KIND_ADD, 100, 200, 0, '0));
        pending_requests.push_back(req(rbse_pkg::KIND_REMOVE, 150, 150, 0, '0));
        pending_requests.push_back(req(rbse_pkg::KIND_FIND_NEXT, 149, 0, 0, '0));
        pending_requests.push_back(req(rbse_pkg::KIND_AND, 0, 0, 1, 64'hF0F0_0000_0000_000F));
        pending_requests.push_back(req(rbse_pkg::KIND_REMOVE, 0, 1023, 0, '0));
      end
      repeat (RANDOM_PER_PHASE) pending_requests.push_back(random_request());
      // block the receiver while the sender keeps offering
      if (p == 0) hold_armed = 1'b1;
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("Covered %0d requests (add %0d, remove %0d, first %0d, next %0d, combine %0d)",
             requests_taken, kind_seen[rbse_pkg::KIND_ADD], kind_seen[rbse_pkg::KIND_REMOVE],
             kind_seen[rbse_pkg::KIND_FIND_FIRST], kind_seen[rbse_pkg::KIND_FIND_NEXT],
             kind_seen[rbse_pkg::KIND_OR] + kind_seen[rbse_pkg::KIND_AND] +
             kind_seen[rbse_pkg::KIND_XOR] + kind_seen[rbse_pkg::KIND_ANDNOT]);
    $display("%0d answers checked, %0d reversed ranges, %0d searches with no member,",
             answers_seen, bad_ranges, none_found, " %0d mismatches", mismatches);
    if (mismatches == 0 && expected_answers.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/core/rbse_pkg.sv
rtl/core/rbse_word_unit.sv
rtl/core/range_bitmap_set_engine_top.sv
bench/range_bitmap_set_engine_top_tb.sv
